>>> rtl/red_pkg.sv
package red_pkg;

	// Width of the running step counter; it saturates at its signed range.
	localparam int COUNT_WIDTH = 16;

	// Fixed field widths.
	localparam int OP_W       = 2;
	localparam int EV_W       = 2;
	localparam int TIME_W     = 32;
	localparam int DEBOUNCE_W = 16;
	localparam int LIMIT_W    = 15;
	localparam int VALUE_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Register reset values.
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(10);
	localparam logic [LIMIT_W-1:0]    LIMIT_RST    = LIMIT_W'(100);

	// Request operations.
	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE     = 2'd0,
		OP_TAKE_EVENT = 2'd1,
		OP_TAKE_COUNT = 2'd2
	} op_t;

	// Event codes.
	typedef enum logic [EV_W-1:0] {
		EV_NONE = 2'd0,
		EV_UP   = 2'd1,
		EV_DOWN = 2'd2
	} ev_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 1'd0,
		REG_LIMIT    = 1'd1
	} reg_idx_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic              pin_a;
		logic              pin_b;
		logic [TIME_W-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [EV_W-1:0]           event_code;
		logic signed [VALUE_W-1:0] count_value;
	} rsp_t;

	typedef struct packed {
		logic [DEBOUNCE_W-1:0] debounce_ms;
		logic [LIMIT_W-1:0]    count_limit;
	} cfg_t;

	// Status visible from the decoder core.
	typedef struct packed {
		logic [EV_W-1:0] held_event;
		logic            prev_a;
	} core_status_t;

endpackage

>>> rtl/red_core.sv
module red_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  red_pkg::req_t         req,
	input  red_pkg::cfg_t         cfg,
	output red_pkg::rsp_t         rsp,
	output red_pkg::core_status_t status
);
	import red_pkg::*;

	localparam int CMP_W = ((COUNT_WIDTH > VALUE_W) ? COUNT_WIDTH : VALUE_W) + 1;
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	logic                          prev_a_q;
	logic [TIME_W-1:0]             last_edge_q;
	logic signed [COUNT_WIDTH-1:0] count_q;
	logic [EV_W-1:0]               held_q;

	logic [TIME_W-1:0]             elapsed;
	logic                          edge_ok;
	logic signed [CMP_W-1:0]       cnt_ext;
	logic signed [CMP_W-1:0]       lim_pos;
	logic signed [CMP_W-1:0]       lim_neg;
	logic signed [CMP_W-1:0]       clamped;
	logic                          prev_a_d;
	logic [TIME_W-1:0]             last_edge_d;
	logic signed [COUNT_WIDTH-1:0] count_d;
	logic [EV_W-1:0]               held_d;

	// A falling edge on A outside the lockout window counts as a step.
	assign elapsed = req.now_ms - last_edge_q;
	assign edge_ok = (elapsed >= TIME_W'(cfg.debounce_ms)) && !req.pin_a && prev_a_q;

	// Clamp the count to the configured magnitude.
	assign cnt_ext = CMP_W'(count_q);
	assign lim_pos = CMP_W'(signed'({1'b0, cfg.count_limit}));
	assign lim_neg = -lim_pos;

	always_comb begin
		if (cnt_ext < lim_neg) begin
			clamped = lim_neg;
		end else if (cnt_ext > lim_pos) begin
			clamped = lim_pos;
		end else begin
			clamped = cnt_ext;
		end
	end

	// Result and next state for the request in hand.
	always_comb begin
		rsp.event_code  = EV_NONE;
		rsp.count_value = '0;
		prev_a_d        = prev_a_q;
		last_edge_d     = last_edge_q;
		count_d         = count_q;
		held_d          = held_q;
		case (req.operation)
			OP_SAMPLE: begin
				prev_a_d = req.pin_a;
				if (edge_ok) begin
					last_edge_d = req.now_ms;
					if (req.pin_b) begin
						rsp.event_code = EV_UP;
						if (count_q != CNT_MAX) begin
							count_d = count_q + COUNT_WIDTH'(1);
						end
					end else begin
						rsp.event_code = EV_DOWN;
						if (count_q != CNT_MIN) begin
							count_d = count_q - COUNT_WIDTH'(1);
						end
					end
					held_d = rsp.event_code;
				end
			end
			OP_TAKE_EVENT: begin
				rsp.event_code = held_q;
				held_d         = EV_NONE;
			end
			OP_TAKE_COUNT: begin
				rsp.count_value = VALUE_W'(clamped);
				count_d         = '0;
			end
			default: begin
			end
		endcase
	end

	// Decoder state, updated once per request taken from the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q    <= 1'b1;
			last_edge_q <= '0;
			count_q     <= '0;
			held_q      <= EV_NONE;
		end else if (fire) begin
			prev_a_q    <= prev_a_d;
			last_edge_q <= last_edge_d;
			count_q     <= count_d;
			held_q      <= held_d;
		end
	end

	assign status.held_event = held_q;
	assign status.prev_a     = prev_a_q;

endmodule

>>> rtl/rotary_encoder_debounced_counter.sv
// Rotary encoder step decoder with debounce lockout and saturating counter.
// A result passes through the input register, then the result register; one request
// per cycle is sustained while the output is not stalled.
// The state update and result come from one pass of logic in the core.
// Reset (arst_n low) sets A history high, count, event and edge time to zero,
// debounce to 10 and count limit to 100; both pipeline stages empty.
module rotary_encoder_debounced_counter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  red_pkg::req_t                        in_req,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output red_pkg::rsp_t                        out_rsp,
	input  logic                                 cfg_we,
	input  logic [red_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [red_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import red_pkg::*;

	logic         valid_s1;
	req_t         req_s1;
	logic         out_valid_q;
	rsp_t         rsp_q;
	cfg_t         cfg_q;
	rsp_t         core_rsp;
	core_status_t core_status;
	logic         out_free;
	logic         fire;
	logic         in_take;

	// The result register frees up when empty or when its result is taken.
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= DEBOUNCE_RST;
			cfg_q.count_limit <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DEBOUNCE: cfg_q.debounce_ms <= cfg_wdata;
				REG_LIMIT:    cfg_q.count_limit <= cfg_wdata[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (out_free || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1 <= in_req;
		end
	end

	red_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.cfg    (cfg_q),
		.rsp    (core_rsp),
		.status (core_status)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= core_rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = rsp_q;

	// A request held in the input stage is not lost while the output is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(req_s1))
		else $error("input stage request dropped while stalled");

	// A counted step is latched as the pending event.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_s1.operation == OP_SAMPLE && core_rsp.event_code != EV_NONE
		|=> core_status.held_event == $past(core_rsp.event_code))
		else $error("detected step not latched as pending event");

	// Taking the pending event clears it.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_s1.operation == OP_TAKE_EVENT |=> core_status.held_event == EV_NONE)
		else $error("pending event not cleared after take");

	// A result never carries both an event and a count.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> rsp_q.event_code == EV_NONE || rsp_q.count_value == '0)
		else $error("result carries both an event and a count");

endmodule

>>> tb/tb_rotary_encoder_debounced_counter.sv
module tb_rotary_encoder_debounced_counter;
	timeunit 1ns;
	timeprecision 1ps;

	import red_pkg::*;

	// Operation code that the block must ignore.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int STEP_MAX = 2 ** (COUNT_WIDTH - 1) - 1;
	localparam int STEP_MIN = -STEP_MAX - 1;
	localparam int ITEMS_PER_PHASE = 320;

	typedef struct {
		req_t req;
		bit   typed;
		rsp_t rsp;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	req_t                  in_req;
	logic                  out_valid;
	logic                  out_stall;
	rsp_t                  out_rsp;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// Shadow copy of the decoder state and its registers.
	logic                  sh_prev_a;
	logic [TIME_W-1:0]     sh_last_edge;
	int                    sh_steps;
	ev_t                   sh_held;
	logic [DEBOUNCE_W-1:0] sh_debounce;
	logic [LIMIT_W-1:0]    sh_limit;

	rsp_t     pending_rsp[$];
	dir_row_t dir_tab[$];
	int       n_errors;
	int       n_requests;
	int       n_results;
	int       n_cycles;
	bit       idle_on;
	bit       stall_on;
	int       hold_len;
	int       b_bias;
	logic     gen_a;
	logic [TIME_W-1:0] gen_tick;

	rotary_encoder_debounced_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rsp   (out_rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run-length guard.
	initial n_cycles = 0;
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("rotary_encoder_debounced_counter test failed");
			$finish;
		end
	end

	// Compute the result of one request and advance the shadow state.
	task automatic decode_step(input req_t r, output rsp_t p);
		logic [TIME_W-1:0] elapsed;
		int                cnt;
		int                lim;
		ev_t               ev;
		ev = EV_NONE;
		cnt = 0;
		case (r.operation)
			OP_SAMPLE: begin
				elapsed = r.now_ms - sh_last_edge;
				if (elapsed >= TIME_W'(sh_debounce) && !r.pin_a && sh_prev_a) begin
					sh_last_edge = r.now_ms;
					if (r.pin_b) begin
						if (sh_steps < STEP_MAX)
							sh_steps++;
						ev = EV_UP;
					end else begin
						if (sh_steps > STEP_MIN)
							sh_steps--;
						ev = EV_DOWN;
					end
					sh_held = ev;
				end
				sh_prev_a = r.pin_a;
			end
			OP_TAKE_EVENT: begin
				ev = sh_held;
				sh_held = EV_NONE;
			end
			OP_TAKE_COUNT: begin
				lim = int'(sh_limit);
				cnt = sh_steps;
				if (cnt < -lim)
					cnt = -lim;
				if (cnt > lim)
					cnt = lim;
				sh_steps = 0;
			end
			default: begin
			end
		endcase
		p.event_code = ev;
		p.count_value = cnt[VALUE_W-1:0];
	endtask

	// Offer one request and record its expected result once accepted.
	task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
		rsp_t p;
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 23) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_req <= r;
		do
			@(posedge clk);
		while (in_stall);
		decode_step(r, p);
		pending_rsp.push_back(typed ? typed_rsp : p);
		n_requests++;
	endtask

	// Stop offering and wait until every expected result has come out.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DEBOUNCE)
			sh_debounce = val[DEBOUNCE_W-1:0];
		else
			sh_limit = val[LIMIT_W-1:0];
	endtask

	// Random request: mostly A toggling with time moving near the lockout window.
	task automatic gen_req(output req_t r);
		int pick;
		pick = $urandom_range(0, 99);
		r.pin_a = 1'($urandom_range(0, 1));
		r.pin_b = 1'($urandom_range(0, 1));
		r.now_ms = $urandom;
		if (pick < 70) begin
			r.operation = OP_SAMPLE;
			if ($urandom_range(0, 99) < 85)
				gen_a = ~gen_a;
			else
				gen_a = 1'($urandom_range(0, 1));
			r.pin_a = gen_a;
			r.pin_b = ($urandom_range(0, 99) < b_bias);
			if ($urandom_range(0, 99) < 88)
				gen_tick = gen_tick + TIME_W'($urandom_range(0, 2 * int'(sh_debounce) + 3));
			else
				gen_tick = $urandom;
			r.now_ms = gen_tick;
		end else if (pick < 84) begin
			r.operation = OP_TAKE_EVENT;
		end else if (pick < 97) begin
			r.operation = OP_TAKE_COUNT;
		end else begin
			r.operation = OP_UNUSED;
		end
	endtask

	function automatic dir_row_t row(input logic [OP_W-1:0] op, input logic a,
			input logic b, input logic [TIME_W-1:0] tick_val, input bit typed,
			input ev_t ev, input logic signed [VALUE_W-1:0] cnt);
		dir_row_t d;
		d.req.operation = op;
		d.req.pin_a = a;
		d.req.pin_b = b;
		d.req.now_ms = tick_val;
		d.typed = typed;
		d.rsp.event_code = ev;
		d.rsp.count_value = cnt;
		return d;
	endfunction

	// Receiver side: random stalls, or a long hold-off when one is requested.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				hold_len = hold_len - 1;
			end else begin
				out_stall <= (stall_on && $urandom_range(0, 99) < 23);
			end
		end
	end

	// Compare each accepted result against the oldest expectation.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result ev=%0d cnt=%0d", $time,
					out_rsp.event_code, out_rsp.count_value);
				n_errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (out_rsp.event_code !== want.event_code) begin
					$display("%0t: event_code expected %0d actual %0d", $time,
						want.event_code, out_rsp.event_code);
					n_errors++;
				end
				if (out_rsp.count_value !== want.count_value) begin
					$display("%0t: count_value expected %0d actual %0d", $time,
						want.count_value, out_rsp.count_value);
					n_errors++;
				end
			end
		end
	end

	initial begin
		req_t r;
		rsp_t no_rsp;
		int   ph;
		logic [CFG_DATA_W-1:0] d_val;
		logic [CFG_DATA_W-1:0] l_val;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		n_errors = 0;
		n_requests = 0;
		n_results = 0;
		idle_on = 1'b1;
		stall_on = 1'b1;
		hold_len = 0;
		b_bias = 50;
		gen_a = 1'b1;
		gen_tick = '0;
		no_rsp = '0;
		sh_prev_a = 1'b1;
		sh_last_edge = '0;
		sh_steps = 0;
		sh_held = EV_NONE;
		sh_debounce = DEBOUNCE_RST;
		sh_limit = LIMIT_RST;

		// Directed requests under the reset register values.
		dir_tab.push_back(row(OP_TAKE_COUNT, 0, 0, 32'd0, 1, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_TAKE_EVENT, 0, 0, 32'd0, 1, EV_NONE, 16'sd0));
		// An edge too soon after reset is locked out.
		dir_tab.push_back(row(OP_SAMPLE, 0, 1, 32'd5, 1, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_SAMPLE, 1, 1, 32'd20, 1, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_SAMPLE, 0, 1, 32'd20, 1, EV_UP, 16'sd0));
		dir_tab.push_back(row(OP_SAMPLE, 1, 0, 32'd25, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_SAMPLE, 0, 0, 32'd25, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_SAMPLE, 1, 0, 32'd30, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_SAMPLE, 0, 0, 32'd30, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_TAKE_EVENT, 1, 1, 32'hFFFF_FFFF, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_TAKE_EVENT, 0, 0, 32'd0, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_UNUSED, 1, 1, 32'hFFFF_FFFF, 1, EV_NONE, 16'sd0));
		// Time difference that wraps past zero.
		dir_tab.push_back(row(OP_SAMPLE, 1, 1, 32'hFFFF_FFFF, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_SAMPLE, 0, 1, 32'hFFFF_FFFF, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_SAMPLE, 1, 1, 32'd5, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_SAMPLE, 0, 1, 32'd8, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_SAMPLE, 1, 1, 32'd9, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_SAMPLE, 0, 1, 32'd9, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_SAMPLE, 0, 1, 32'd100, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_TAKE_COUNT, 0, 0, 32'd0, 0, EV_NONE, 16'sd0));
		dir_tab.push_back(row(OP_TAKE_COUNT, 1, 1, 32'd0, 0, EV_NONE, 16'sd0));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);
		drain();

		// Random phases over several register settings, extremes included.
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin d_val = 16'd0;     l_val = 16'd0;     end
				1: begin d_val = 16'hFFFF;  l_val = 16'hFFFF;  end
				2: begin d_val = 16'd3;     l_val = 16'd5;     end
				3: begin
					d_val = CFG_DATA_W'($urandom_range(0, 40));
					l_val = CFG_DATA_W'($urandom);
				end
				default: begin d_val = 16'd1; l_val = 16'h8007; end
			endcase
			write_reg(REG_DEBOUNCE, d_val);
			write_reg(REG_LIMIT, l_val);
			idle_on = (ph != 1);
			stall_on = (ph != 1);
			b_bias = $urandom_range(10, 90);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// Hold the receiver off long enough to back the block up.
				if (ph == 2 && i == 100)
					hold_len = 80;
				gen_req(r);
				send_req(r, 1'b0, no_rsp);
			end
			drain();
		end

		$display("Covered %0d requests and %0d results over %0d directed rows,", n_requests,
			n_results, dir_tab.size());
		$display("five register settings, wrapped tick differences and a receiver hold-off.");
		if (n_errors == 0) begin
			$display("rotary_encoder_debounced_counter test passed");
		end else begin
			$display("rotary_encoder_debounced_counter test failed");
		end
		$finish;
	end

endmodule

>>> rotary_encoder_debounced_counter.f
rtl/red_pkg.sv
rtl/red_core.sv
rtl/rotary_encoder_debounced_counter.sv
tb/tb_rotary_encoder_debounced_counter.sv
